FILE: rtl/pid_pkg.sv
// Package for the PID controller with derivative on measurement.
// Holds data widths, fixed-point constants and register indexes.
// No dependencies.
`default_nettype none

package pid_pkg;

  // Signal and gain format: signed Q16.16 in 32 bits
  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  // Time step: unsigned Q8.16
  localparam int DtWidth   = 24;
  localparam int DtFrac    = 16;
  localparam int LimWidth  = 31;

  // Register file
  localparam int NumRegs   = 8;
  localparam int AddrWidth = 5;

  // Filter coefficients, Q0.16
  localparam logic signed [32:0] ALPHA_Q16     = 33'sd19661;
  localparam logic signed [32:0] ONE_MINUS_Q16 = 33'sd45875;

  // Register indexes
  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_TARGET    = 3'd3;
  localparam logic [2:0] REG_DRIVE_MIN = 3'd4;
  localparam logic [2:0] REG_DRIVE_MAX = 3'd5;
  localparam logic [2:0] REG_INT_LIM   = 3'd6;
  localparam logic [2:0] REG_ENABLE    = 3'd7;

  // Reset values
  localparam logic signed [31:0] RST_GAIN_P    = 32'sd65536;
  localparam logic signed [31:0] RST_DRIVE_MIN = -32'sd6553600;
  localparam logic signed [31:0] RST_DRIVE_MAX = 32'sd6553600;
  localparam logic [30:0]        RST_INT_LIM   = 31'd6553600;

endpackage

`default_nettype wire

FILE: rtl/pid_if.sv
// Stream interfaces of the PID controller: sample input and drive output.
// Depends on pid_pkg for field widths.
`default_nettype none

interface pid_meas_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [pid_pkg::DataWidth-1:0]    measurement;
  logic        [pid_pkg::DtWidth-1:0]      time_step;
  modport source (output valid, measurement, time_step, input ready);
  modport sink   (input valid, measurement, time_step, output ready);
endinterface

interface pid_drive_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [pid_pkg::DataWidth-1:0]    drive;
  logic                                    skipped;
  modport source (output valid, drive, skipped, input ready);
  modport sink   (input valid, drive, skipped, output ready);
endinterface

`default_nettype wire

FILE: rtl/pid_controller_deriv_on_meas.sv
// PID controller, derivative on measurement, Q16.16, one shared 33x33 multiplier.
// The slope comes from a bit-serial slope divider; a skipped sample bypasses the
// datapath and goes straight to the output register. One sample in flight.
// A new sample is taken once the previous result sits in the output register.
// Reset (rst, synchronous): registers to defaults, state cleared, disabled.
`default_nettype none

module pid_controller_deriv_on_meas (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pid_pkg::AddrWidth-1:0]       paddr,
  input  wire logic [31:0]                         pwdata,
  output logic      [31:0]                         prdata,
  output logic                                     pready,
  pid_meas_if.sink                                 sample,
  pid_drive_if.source                              result
);

  localparam int DivBits = pid_pkg::DataWidth + 1 + pid_pkg::DtFrac; // 49

  typedef enum logic [3:0] {
    S_IDLE, S_P, S_STEP, S_INT, S_I, S_IACC, S_DIV, S_SLOPE,
    S_FA, S_FB, S_FS, S_D, S_SUM, S_CLAMP, S_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic signed [31:0] gain_p, gain_i, gain_d, target, drive_min, drive_max;
  logic        [30:0] integral_limit;
  logic               enable;

  // Controller state
  logic signed [31:0] integral_sum, previous_measurement, filtered_slope;

  // Working registers
  logic signed [31:0] meas;
  logic        [23:0] dt;
  logic signed [32:0] err, diff;
  logic signed [65:0] prod;
  logic signed [51:0] acc;
  logic signed [32:0] fsa;
  logic signed [31:0] slope;
  logic        [23:0] rem;
  logic [DivBits-1:0] nq;
  logic               qneg;
  logic         [5:0] cnt;
  logic signed [31:0] out_drive;
  logic               out_skipped;
  logic signed [31:0] res_drive;
  logic               res_skipped;
  logic               res_valid;

  // Shared multiplier operands
  logic signed [32:0] mul_a, mul_b;
  logic signed [49:0] prod_sh;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Register read
  always_comb begin
    unique case (paddr[4:2])
      pid_pkg::REG_GAIN_P:    prdata = gain_p;
      pid_pkg::REG_GAIN_I:    prdata = gain_i;
      pid_pkg::REG_GAIN_D:    prdata = gain_d;
      pid_pkg::REG_TARGET:    prdata = target;
      pid_pkg::REG_DRIVE_MIN: prdata = drive_min;
      pid_pkg::REG_DRIVE_MAX: prdata = drive_max;
      pid_pkg::REG_INT_LIM:   prdata = {1'b0, integral_limit};
      pid_pkg::REG_ENABLE:    prdata = {31'd0, enable};
      default:                prdata = 32'd0;
    endcase
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    unique case (state)
      S_P:     begin mul_a = 33'(gain_p);       mul_b = err; end
      S_STEP:  begin mul_a = err;               mul_b = $signed({9'd0, dt}); end
      S_I:     begin mul_a = 33'(gain_i);       mul_b = 33'(integral_sum); end
      S_FA:    begin mul_a = 33'(slope);        mul_b = pid_pkg::ALPHA_Q16; end
      S_FB:    begin mul_a = 33'(filtered_slope); mul_b = pid_pkg::ONE_MINUS_Q16; end
      S_D:     begin mul_a = 33'(gain_d);       mul_b = 33'(filtered_slope); end
      default: begin mul_a = 33'sd0;            mul_b = 33'sd0; end
    endcase
  end

  assign prod_sh = 50'(prod >>> pid_pkg::FracBits);

  // Integral update with anti-windup clamp
  logic signed [43:0] int_raw, lim_pos;
  logic signed [31:0] int_next;
  always_comb begin
    int_raw = 44'(integral_sum) + 44'(prod_sh);
    lim_pos = $signed({13'd0, integral_limit});
    if (int_raw > lim_pos)       int_next = 32'(lim_pos);
    else if (int_raw < -lim_pos) int_next = 32'(-lim_pos);
    else                         int_next = 32'(int_raw);
  end

  // Divider step: restoring, one quotient bit per cycle
  logic [24:0] rem_sh, rem_sub;
  logic        div_ge;
  always_comb begin
    rem_sh  = {rem, nq[DivBits-1]};
    rem_sub = rem_sh - {1'b0, dt};
    div_ge  = (rem_sh >= {1'b0, dt});
  end

  // Signed slope with saturation to 32 bits
  logic signed [31:0] slope_next;
  always_comb begin
    if (qneg) begin
      if (nq > DivBits'(33'h080000000)) slope_next = 32'sh80000000;
      else                              slope_next = 32'(-$signed({1'b0, nq}));
    end else begin
      if (nq > DivBits'(33'h07FFFFFFF)) slope_next = 32'sh7FFFFFFF;
      else                              slope_next = 32'(nq);
    end
  end

  // Filter sum with saturation
  logic signed [50:0] fs_raw;
  logic signed [31:0] fs_next;
  always_comb begin
    fs_raw = 51'(fsa) + 51'(prod_sh);
    if (fs_raw > 51'sh7FFFFFFF)       fs_next = 32'sh7FFFFFFF;
    else if (fs_raw < -51'sh80000000) fs_next = 32'sh80000000;
    else                              fs_next = 32'(fs_raw);
  end

  // Output clamp: max first, then min wins
  logic signed [31:0] drive_next;
  always_comb begin
    if (acc > 52'(drive_max))      drive_next = (drive_max < drive_min) ? drive_min : drive_max;
    else if (acc < 52'(drive_min)) drive_next = drive_min;
    else                           drive_next = 32'(acc);
  end

  assign sample.ready   = (state == S_IDLE);
  assign result.valid   = res_valid;
  assign result.drive   = res_drive;
  assign result.skipped = res_skipped;

  // Sequencer, datapath and register file
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      res_valid            <= 1'b0;
      gain_p               <= pid_pkg::RST_GAIN_P;
      gain_i               <= 32'sd0;
      gain_d               <= 32'sd0;
      target               <= 32'sd0;
      drive_min            <= pid_pkg::RST_DRIVE_MIN;
      drive_max            <= pid_pkg::RST_DRIVE_MAX;
      integral_limit       <= pid_pkg::RST_INT_LIM;
      enable               <= 1'b0;
      integral_sum         <= 32'sd0;
      previous_measurement <= 32'sd0;
      filtered_slope       <= 32'sd0;
      cnt                  <= 6'd0;
    end else begin
      // Output register: load on commit, drop after the transfer
      if (state == S_DONE && (!res_valid || result.ready)) begin
        res_valid   <= 1'b1;
        res_drive   <= out_drive;
        res_skipped <= out_skipped;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      if (cfg_wr) begin
        unique case (paddr[4:2])
          pid_pkg::REG_GAIN_P:    gain_p <= pwdata;
          pid_pkg::REG_GAIN_I:    gain_i <= pwdata;
          pid_pkg::REG_GAIN_D:    gain_d <= pwdata;
          pid_pkg::REG_TARGET:    target <= pwdata;
          pid_pkg::REG_DRIVE_MIN: drive_min <= pwdata;
          pid_pkg::REG_DRIVE_MAX: drive_max <= pwdata;
          pid_pkg::REG_INT_LIM:   integral_limit <= pwdata[30:0];
          pid_pkg::REG_ENABLE: begin
            enable               <= pwdata[0];
            integral_sum         <= 32'sd0;
            previous_measurement <= 32'sd0;
            filtered_slope       <= 32'sd0;
          end
          default: ;
        endcase
      end

      prod <= mul_a * mul_b;

      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            meas <= sample.measurement;
            dt   <= sample.time_step;
            err  <= 33'(target) - 33'(sample.measurement);
            diff <= 33'(sample.measurement) - 33'(previous_measurement);
            if (!enable || sample.time_step == 24'd0) begin
              out_drive   <= 32'sd0;
              out_skipped <= 1'b1;
              state       <= S_DONE;
            end else begin
              out_skipped <= 1'b0;
              state       <= S_P;
            end
          end
        end
        S_P:    state <= S_STEP;
        S_STEP: begin
          acc   <= 52'(prod_sh);
          state <= S_INT;
        end
        S_INT: begin
          integral_sum <= int_next;
          state        <= S_I;
        end
        S_I:    state <= S_IACC;
        S_IACC: begin
          acc  <= acc + 52'(prod_sh);
          qneg <= diff[32];
          nq   <= {(diff[32] ? 33'(-diff) : diff), 16'd0};
          rem  <= 24'd0;
          cnt  <= 6'(DivBits);
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= div_ge ? rem_sub[23:0] : rem_sh[23:0];
          nq  <= {nq[DivBits-2:0], div_ge};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) state <= S_SLOPE;
        end
        S_SLOPE: begin
          slope <= slope_next;
          state <= S_FA;
        end
        S_FA:   state <= S_FB;
        S_FB: begin
          fsa   <= 33'(prod_sh);
          state <= S_FS;
        end
        S_FS: begin
          filtered_slope <= fs_next;
          state          <= S_D;
        end
        S_D:    state <= S_SUM;
        S_SUM: begin
          acc   <= acc - 52'(prod_sh);
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          out_drive            <= drive_next;
          previous_measurement <= meas;
          state                <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || result.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: tb/pid_controller_deriv_on_meas_tb.sv
// Testbench for pid_controller_deriv_on_meas: drives samples and APB register writes,
// predicts each drive value in fixed point and compares it with the result stream.
// Depends on pid_pkg and the stream interfaces pid_meas_if and pid_drive_if.
`default_nettype none

module pid_controller_deriv_on_meas_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;
  typedef struct {
    logic signed [31:0] measurement;
    logic        [23:0] time_step;
  } sample_t;
  typedef struct {
    logic signed [31:0] drive;
    logic               skipped;
  } drive_t;

  localparam longint S64_MAX = 64'sh7fffffffffffffff;
  localparam longint S64_MIN = -S64_MAX - 1;
  localparam int     SettleCycles = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [pid_pkg::AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pid_meas_if  sample_bus ();
  pid_drive_if result_bus ();

  pid_controller_deriv_on_meas dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .sample(sample_bus), .result(result_bus)
  );

  // Clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Controller copy: configuration and loop state
  longint kp, ki, kd, setpoint, out_lo, out_hi, int_bound;
  bit     running;
  longint int_acc, last_meas, slope_filt;

  sample_t pending_samples[$];
  drive_t  expected_drives[$];
  int      send_idle_pct = 0, recv_stall_pct = 0;
  int      hold_token = 0, hold_seen = 0, hold_left = 0;
  int      errors = 0, samples_sent = 0, drives_checked = 0, skips_seen = 0;
  int      config_writes = 0;

  function automatic longint sat64(wide_t x);
    if (x > wide_t'(S64_MAX)) return S64_MAX;
    if (x < wide_t'(S64_MIN)) return S64_MIN;
    return longint'(x);
  endfunction

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // floor(a*b / 2^sh), saturated to 64 bits
  function automatic longint scaled_product(longint a, longint b, int sh);
    wide_t prod;
    prod = wide_t'(a) * wide_t'(b);
    return sat64(prod >>> sh);
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    return sat64(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [31:0] val);
    case (idx)
      pid_pkg::REG_GAIN_P:    kp = longint'(signed'(val));
      pid_pkg::REG_GAIN_I:    ki = longint'(signed'(val));
      pid_pkg::REG_GAIN_D:    kd = longint'(signed'(val));
      pid_pkg::REG_TARGET:    setpoint = longint'(signed'(val));
      pid_pkg::REG_DRIVE_MIN: out_lo = longint'(signed'(val));
      pid_pkg::REG_DRIVE_MAX: out_hi = longint'(signed'(val));
      pid_pkg::REG_INT_LIM:   int_bound = longint'({33'd0, val[30:0]});
      pid_pkg::REG_ENABLE: begin
        running = val[0];
        int_acc = 0;
        last_meas = 0;
        slope_filt = 0;
      end
      default: ;
    endcase
  endfunction

  // One control step; updates loop state like the block does
  function automatic drive_t control_step(sample_t s);
    drive_t r;
    longint meas, dt, err, p_term, i_term, d_term, slope, total;
    meas = longint'(s.measurement);
    dt = longint'({40'd0, s.time_step});
    if (!running || dt == 0) begin
      r.drive = '0;
      r.skipped = 1'b1;
      return r;
    end
    err = setpoint - meas;
    p_term = scaled_product(kp, err, pid_pkg::FracBits);
    int_acc = sat_sum(int_acc, scaled_product(err, dt, pid_pkg::DtFrac));
    if (int_acc > int_bound) int_acc = int_bound;
    if (int_acc < -int_bound) int_acc = -int_bound;
    int_acc = sat32(int_acc);
    i_term = scaled_product(ki, int_acc, pid_pkg::FracBits);
    slope = sat32(((meas - last_meas) * 64'sd65536) / dt);
    slope_filt = sat32(sat_sum(scaled_product(slope, 19661, 16),
                               scaled_product(slope_filt, 45875, 16)));
    d_term = scaled_product(kd, slope_filt, pid_pkg::FracBits);
    total = sat_sum(sat_sum(p_term, i_term), (d_term == S64_MIN) ? S64_MAX : -d_term);
    if (total > out_hi) total = out_hi;
    if (total < out_lo) total = out_lo;
    last_meas = meas;
    r.drive = total[31:0];
    r.skipped = 1'b0;
    return r;
  endfunction

  // Sample driver: predicts on every transfer, then offers the next sample
  always @(posedge clk) begin
    if (rst) begin
      sample_bus.valid <= 1'b0;
      sample_bus.measurement <= '0;
      sample_bus.time_step <= '0;
    end else begin
      if (sample_bus.valid && sample_bus.ready) begin
        sample_t s;
        s.measurement = sample_bus.measurement;
        s.time_step = sample_bus.time_step;
        expected_drives.push_back(control_step(s));
        samples_sent++;
      end
      if (!sample_bus.valid || sample_bus.ready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_t nxt;
          nxt = pending_samples.pop_front();
          sample_bus.valid <= 1'b1;
          sample_bus.measurement <= nxt.measurement;
          sample_bus.time_step <= nxt.time_step;
        end else begin
          sample_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= 400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (expected_drives.size() == 0) begin
          errors++;
          $display("%0t: unexpected result drive=%0d skipped=%0b", $time,
                   result_bus.drive, result_bus.skipped);
        end else begin
          drive_t e;
          e = expected_drives.pop_front();
          if (e.drive !== result_bus.drive) begin
            errors++;
            $display("%0t: drive expected %0d actual %0d", $time, e.drive, result_bus.drive);
          end
          if (e.skipped !== result_bus.skipped) begin
            errors++;
            $display("%0t: skipped expected %0b actual %0b", $time, e.skipped,
                     result_bus.skipped);
          end
          drives_checked++;
          if (e.skipped) skips_seen++;
        end
      end
      result_bus.ready <= (hold_left == 0 && hold_token == hold_seen)
                          && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // APB write: setup, then access
  task automatic write_register(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pid_pkg::AddrWidth'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    apply_register(idx, val);
    config_writes++;
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || sample_bus.valid || expected_drives.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic add_sample(logic [31:0] m, logic [23:0] dt);
    sample_t s;
    s.measurement = m;
    s.time_step = dt;
    pending_samples.push_back(s);
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'h1;
      default: return 32'hffffffff;
    endcase
  endfunction

  function automatic logic [31:0] small_signed(int unsigned span);
    logic [31:0] v;
    v = $urandom_range(span);
    return $urandom_range(1) ? -v : v;
  endfunction

  // Full register setup; style 0 moderate, 1 extremes, 2 inverted clamps
  task automatic setup_controller(int style, bit en);
    logic [31:0] lo, hi;
    if (style == 1) begin
      write_register(pid_pkg::REG_GAIN_P, pick_extreme());
      write_register(pid_pkg::REG_GAIN_I, pick_extreme());
      write_register(pid_pkg::REG_GAIN_D, pick_extreme());
      write_register(pid_pkg::REG_TARGET, pick_extreme());
      write_register(pid_pkg::REG_DRIVE_MIN, 32'h80000000);
      write_register(pid_pkg::REG_DRIVE_MAX, 32'h7fffffff);
      write_register(pid_pkg::REG_INT_LIM, $urandom_range(1) ? 32'h7fffffff : 32'h0);
    end else begin
      write_register(pid_pkg::REG_GAIN_P, small_signed(32'h40000));
      write_register(pid_pkg::REG_GAIN_I, small_signed(32'h20000));
      write_register(pid_pkg::REG_GAIN_D, small_signed(32'h8000));
      write_register(pid_pkg::REG_TARGET, small_signed(32'h640000));
      lo = -$urandom_range(32'h1000000);
      hi = $urandom_range(32'h1000000);
      write_register(pid_pkg::REG_DRIVE_MIN, (style == 2) ? hi + 32'h10000 : lo);
      write_register(pid_pkg::REG_DRIVE_MAX, (style == 2) ? lo : hi);
      write_register(pid_pkg::REG_INT_LIM, {$urandom} >> ($urandom_range(31) + 1));
    end
    write_register(pid_pkg::REG_ENABLE, {31'd0, en});
  endtask

  // Mostly samples near the setpoint with sane time steps, some raw noise
  task automatic queue_random(int count);
    repeat (count) begin
      if ($urandom_range(99) < 80)
        add_sample(setpoint[31:0] + small_signed(32'h80000), $urandom_range(1, 32'h30000));
      else
        add_sample($urandom, ($urandom_range(9) == 0) ? 24'd0 : 24'($urandom));
    end
  endtask

  // Stimulus
  initial begin
    int phase;
    kp = 65536; ki = 0; kd = 0; setpoint = 0;
    out_lo = -6553600; out_hi = 6553600; int_bound = 6553600;
    running = 1'b0; int_acc = 0; last_meas = 0; slope_filt = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Disabled after reset: every sample is skipped
    add_sample(32'h00010000, 24'h010000);
    add_sample(32'h7fffffff, 24'hffffff);
    wait_idle();

    // Default gains, enabled: first-sample kick, zero time step, field extremes
    write_register(pid_pkg::REG_ENABLE, 32'd1);
    add_sample(32'h00050000, 24'h010000);
    add_sample(32'h00050000, 24'd0);
    add_sample(32'h7fffffff, 24'd1);
    add_sample(32'h80000000, 24'd1);
    add_sample(32'h80000000, 24'hffffff);
    add_sample(32'h7fffffff, 24'hffffff);
    add_sample(32'h0, 24'h800000);
    wait_idle();

    // Extreme gains and wide limits drive the sums toward saturation
    write_register(pid_pkg::REG_GAIN_P, 32'h7fffffff);
    write_register(pid_pkg::REG_GAIN_I, 32'h80000000);
    write_register(pid_pkg::REG_GAIN_D, 32'h7fffffff);
    write_register(pid_pkg::REG_TARGET, 32'h7fffffff);
    write_register(pid_pkg::REG_DRIVE_MIN, 32'h80000000);
    write_register(pid_pkg::REG_DRIVE_MAX, 32'h7fffffff);
    write_register(pid_pkg::REG_INT_LIM, 32'h7fffffff);
    write_register(pid_pkg::REG_ENABLE, 32'd1);
    add_sample(32'h80000000, 24'hffffff);
    add_sample(32'h7fffffff, 24'd1);
    add_sample(32'h80000000, 24'd1);
    add_sample(32'h00000001, 24'h000100);
    add_sample(32'hffffffff, 24'h7fffff);
    wait_idle();

    // Inverted clamps, zero integral bound
    write_register(pid_pkg::REG_DRIVE_MIN, 32'h00100000);
    write_register(pid_pkg::REG_DRIVE_MAX, 32'hfff00000);
    write_register(pid_pkg::REG_INT_LIM, 32'd0);
    add_sample(32'h00020000, 24'h010000);
    add_sample(32'hfffe0000, 24'h008000);
    add_sample(32'h12345678, 24'h020000);
    wait_idle();

    // Random phases rotating through the idle patterns
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      setup_controller((phase == 3) ? 1 : (phase == 5) ? 2 : 0, phase != 6);
      if (phase == 2) hold_token++;
      queue_random((phase == 6) ? 40 : 180);
      wait_idle();
    end

    $display("ran %0d samples, %0d results checked (%0d skipped), %0d register writes",
             samples_sent, drives_checked, skips_seen, config_writes);
    if (errors == 0) begin
      $display("pid_controller_deriv_on_meas: match");
    end else begin
      $display("pid_controller_deriv_on_meas: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("pid_controller_deriv_on_meas: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
